// ===== src/lav_pkg.sv =====
// Shared constants and types for the look-at view matrix block.
package lav_pkg;

  // Coordinate word: signed fixed point
  localparam int COORD_W = 32;
  typedef logic signed [COORD_W-1:0] coord_t;

  // Input transaction: eye, target, up vector, three coordinates each
  localparam int IN_TW = 9 * COORD_W;

  // Normalization: largest magnitude is brought to bit NORM_POS
  localparam int NORM_POS = 29;
  localparam int NORM_W   = NORM_POS + 1;

  // Squared length and its integer square root
  localparam int SQ_W     = 2 * NORM_W + 2;
  localparam int RT_STEPS = 31;
  localparam int ROOT_W   = 31;

endpackage

// ===== src/lav_unit3.sv =====
// Pipelined three-component vector normalizer with a carried sideband.
module lav_unit3 #(
  parameter int IN_W      = 33,
  parameter int SIDE_W    = 192,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [2:0][IN_W-1:0]         vec,
  input  logic [SIDE_W-1:0]            side_in,
  output logic                         out_valid,
  output logic [2:0][FRAC_BITS+1:0]    unit_vec,
  output logic                         zero,
  output logic [SIDE_W-1:0]            side_out
);
  import lav_pkg::*;

  localparam int NG     = (IN_W + 7) / 8;
  localparam int XW     = NG * 8;
  localparam int PW     = $clog2(XW);
  localparam int WW     = XW + NORM_W;
  localparam int QW     = FRAC_BITS + 1;
  localparam int OW     = FRAC_BITS + 2;
  localparam int RW     = FRAC_BITS + NORM_W + 2;
  localparam int ST_RT  = 6;
  localparam int ST_NUM = ST_RT + RT_STEPS;
  localparam int ST_DV  = ST_NUM + 1;
  localparam int ST_OUT = ST_DV + QW;
  localparam int NST    = ST_OUT + 1;

  // Valid bits and carried fields, one entry per stage; the signs stop before the output stage
  logic [NST-1:0]    v;
  logic [SIDE_W-1:0] side_q [NST];
  logic [2:0]        sgn_q  [ST_OUT];
  logic [NST-1:0]    zero_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= side_in;
      sgn_q[0]  <= {vec[2][IN_W-1], vec[1][IN_W-1], vec[0][IN_W-1]};
      zero_q[0] <= (vec == '0);
      for (int k = 1; k < NST; k++) begin
        side_q[k] <= side_q[k-1];
        zero_q[k] <= zero_q[k-1];
      end
      for (int k = 1; k < ST_OUT; k++) begin
        sgn_q[k] <= sgn_q[k-1];
      end
    end
  end

  // Stage 0: magnitudes
  logic [IN_W-1:0] mag0 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag0[i] <= vec[i][IN_W-1] ? IN_W'(-vec[i]) : vec[i];
      end
    end
  end

  // Stage 1: leading one inside each byte of the combined magnitude
  logic [XW-1:0]   mx;
  logic [NG-1:0]   gnz_c;
  logic [2:0]      glead_c [NG];
  logic [NG-1:0]   gnz1;
  logic [2:0]      glead1 [NG];
  logic [IN_W-1:0] mag1 [3];

  always_comb begin
    mx = XW'(mag0[0] | mag0[1] | mag0[2]);
    for (int g = 0; g < NG; g++) begin
      gnz_c[g]   = |mx[g*8 +: 8];
      glead_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mx[g*8+b]) glead_c[g] = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gnz1   <= gnz_c;
      glead1 <= glead_c;
      mag1   <= mag0;
    end
  end

  // Stage 2: pick the highest nonzero byte
  logic [PW-1:0]   pos_c, pos2;
  logic [IN_W-1:0] mag2 [3];

  always_comb begin
    pos_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz1[g]) pos_c = PW'(g * 8) + PW'(glead1[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos2 <= pos_c;
      mag2 <= mag1;
    end
  end

  // Stage 3: common shift so the leading one lands on NORM_POS
  logic [WW-1:0]     wide_c [3];
  logic [NORM_W-1:0] m3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(pos2) < NORM_POS) begin
        wide_c[i] = WW'(mag2[i]) << (NORM_POS - int'(pos2));
      end else begin
        wide_c[i] = WW'(mag2[i]) >> (int'(pos2) - NORM_POS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        m3[i] <= wide_c[i][NORM_W-1:0];
      end
    end
  end

  // Stage 4: squares
  logic [2*NORM_W-1:0] sq4 [3];
  logic [NORM_W-1:0]   m4 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= (2*NORM_W)'(m3[i]) * (2*NORM_W)'(m3[i]);
      end
      m4 <= m3;
    end
  end

  // Stage 5: squared length
  logic [SQ_W-1:0]   sum5;
  logic [NORM_W-1:0] m5 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      sum5 <= SQ_W'(sq4[0]) + SQ_W'(sq4[1]) + SQ_W'(sq4[2]);
      m5   <= m4;
    end
  end

  // Square root, one result bit per stage
  logic [SQ_W-1:0]   rt_x [RT_STEPS];
  logic [SQ_W-1:0]   rt_r [RT_STEPS];
  logic [NORM_W-1:0] rt_m [RT_STEPS][3];

  for (genvar j = 0; j < RT_STEPS; j++) begin : g_root
    localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (SQ_W - 2 - 2 * j);
    logic [SQ_W-1:0]   x_in, r_in, trial;
    logic [NORM_W-1:0] m_in [3];
    if (j == 0) begin : g_first
      assign x_in = sum5;
      assign r_in = '0;
      assign m_in = m5;
    end else begin : g_next
      assign x_in = rt_x[j-1];
      assign r_in = rt_r[j-1];
      assign m_in = rt_m[j-1];
    end
    assign trial = r_in + RBIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        if (x_in >= trial) begin
          rt_x[j] <= x_in - trial;
          rt_r[j] <= (r_in >> 1) + RBIT;
        end else begin
          rt_x[j] <= x_in;
          rt_r[j] <= r_in >> 1;
        end
        rt_m[j] <= m_in;
      end
    end
  end

  // Numerators with half the root added for rounding
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] nroot;
  logic [RW-1:0]     num [3];
  assign root = rt_r[RT_STEPS-1][ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        num[i] <= (RW'(rt_m[RT_STEPS-1][i]) << FRAC_BITS) + RW'(root >> 1);
      end
      nroot <= root;
    end
  end

  // Restoring division, one quotient bit per stage, three lanes
  logic [RW-1:0]     dv_r [QW][3];
  logic [QW-1:0]     dv_q [QW][3];
  logic [ROOT_W-1:0] dv_n [QW];

  for (genvar d = 0; d < QW; d++) begin : g_div
    localparam int QB = QW - 1 - d;
    logic [RW-1:0]     r_in [3];
    logic [QW-1:0]     q_in [3];
    logic [ROOT_W-1:0] n_in;
    logic [RW-1:0]     dsub;
    if (d == 0) begin : g_first
      assign r_in = num;
      assign n_in = nroot;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign q_in[i] = '0;
      end
    end else begin : g_next
      assign r_in = dv_r[d-1];
      assign q_in = dv_q[d-1];
      assign n_in = dv_n[d-1];
    end
    assign dsub = RW'(n_in) << QB;
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dsub) begin
            dv_r[d][i] <= r_in[i] - dsub;
            dv_q[d][i] <= q_in[i] | (QW'(1) << QB);
          end else begin
            dv_r[d][i] <= r_in[i];
            dv_q[d][i] <= q_in[i];
          end
        end
        dv_n[d] <= n_in;
      end
    end
  end

  // Output stage: restore signs, force zero for a zero-length vector
  logic [OW-1:0] qext [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qext[i] = OW'(dv_q[QW-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_q[ST_OUT-1]) begin
          unit_vec[i] <= '0;
        end else begin
          unit_vec[i] <= sgn_q[ST_OUT-1][i] ? -qext[i] : qext[i];
        end
      end
    end
  end

  assign out_valid = v[NST-1];
  assign zero      = zero_q[NST-1];
  assign side_out  = side_q[NST-1];

endmodule

// ===== src/look_at_view_matrix.sv =====
// Top level: right-handed look-at view matrix, streaming in and out.
//
//  channel | direction | width                     | contents
//  --------+-----------+---------------------------+--------------------------------------
//  s_*     | in        | 288                       | eye, target, up vector (Q16.16 each)
//  m_*     | out       | 9*(FRAC_BITS+2)+96, bytes | side, true up, back, translations
//
//  One transaction per cycle is accepted and delivered when neither side stalls.
//  Each of the two normalizers holds a 31-step square root and a FRAC_BITS+1
//  step divider.
//  Reset clears all valid bits; no payload register is reset.
//  The output register has a one-entry skid behind it; while the skid holds a
//  result the whole pipeline holds and s_tready is low.
module look_at_view_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, upvec_x, upvec_y, upvec_z
  input  logic [lav_pkg::IN_TW-1:0]      s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // side_x/y/z, true_up_x/y/z, back_x/y/z, shift_x/y/z, zero fill to bytes
  output logic [((9*(FRAC_BITS+2)+3*lav_pkg::COORD_W+7)/8)*8-1:0] m_tdata
);
  import lav_pkg::*;

  localparam int OW      = FRAC_BITS + 2;
  localparam int DIN_W   = COORD_W + 1;
  localparam int CW      = FRAC_BITS + 34;
  localparam int BW      = 2 * OW;
  localparam int EW      = OW + COORD_W;
  localparam int DW      = FRAC_BITS + 35;
  localparam int FLD_W   = 9 * OW + 3 * COORD_W;
  localparam int OUT_W   = $bits(m_tdata);
  localparam int SIDE1_W = 6 * COORD_W;
  localparam int SIDE2_W = 3 * OW + 3 * COORD_W;
  localparam logic [DW-1:0]        HALF  = DW'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

  // Shift right by FRAC_BITS, rounding half away from zero
  function automatic logic signed [DW-1:0] rnd(input logic signed [DW-1:0] x);
    logic [DW-1:0] m;
    logic [DW-1:0] r;
    m = x[DW-1] ? DW'(-x) : DW'(x);
    r = (m + HALF) >> FRAC_BITS;
    return x[DW-1] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [OW-1:0] clamp_one(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] y;
    if (x > ONE_D) begin
      y = ONE_D;
    end else if (x < -ONE_D) begin
      y = -ONE_D;
    end else begin
      y = x;
    end
    return OW'(y);
  endfunction

  function automatic coord_t sat32(input logic signed [DW-1:0] x);
    if (x[DW-1:COORD_W-1] != {(DW-COORD_W+1){x[DW-1]}}) begin
      return x[DW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end
    return x[COORD_W-1:0];
  endfunction

  logic adv;
  logic sv, ov;
  logic [OUT_W-1:0] sd, od, pd;

  // Stage A: register inputs, form target minus eye
  logic va;
  logic [2:0][COORD_W-1:0] eye_a, upv_a;
  logic [2:0][DIN_W-1:0]   d_a;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        eye_a[i] <= s_tdata[COORD_W*i +: COORD_W];
        upv_a[i] <= s_tdata[COORD_W*(6+i) +: COORD_W];
        d_a[i]   <= DIN_W'($signed(s_tdata[COORD_W*(3+i) +: COORD_W]))
                  - DIN_W'($signed(s_tdata[COORD_W*i +: COORD_W]));
      end
    end
  end

  // Forward axis
  logic                    v1;
  logic [2:0][OW-1:0]      f1;
  logic [SIDE1_W-1:0]      side1;
  logic [2:0][COORD_W-1:0] eye1, upv1;

  lav_unit3 #(
    .IN_W      (DIN_W),
    .SIDE_W    (SIDE1_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (va),
    .vec       (d_a),
    .side_in   ({upv_a, eye_a}),
    .out_valid (v1),
    .unit_vec  (f1),
    .zero      (),
    .side_out  (side1)
  );

  assign {upv1, eye1} = side1;

  // Stage B1: products of forward and up vector
  logic vb1, vb2;
  logic signed [CW-1:0]    pb [6];
  logic [2:0][COORD_W-1:0] eye_b1, eye_b2;
  logic [2:0][OW-1:0]      f_b1, f_b2;
  logic [2:0][CW-1:0]      c_b2;

  always_ff @(posedge clk) begin
    if (adv) begin
      pb[0]  <= CW'($signed(f1[1])) * CW'($signed(upv1[2]));
      pb[1]  <= CW'($signed(f1[2])) * CW'($signed(upv1[1]));
      pb[2]  <= CW'($signed(f1[2])) * CW'($signed(upv1[0]));
      pb[3]  <= CW'($signed(f1[0])) * CW'($signed(upv1[2]));
      pb[4]  <= CW'($signed(f1[0])) * CW'($signed(upv1[1]));
      pb[5]  <= CW'($signed(f1[1])) * CW'($signed(upv1[0]));
      eye_b1 <= eye1;
      f_b1   <= f1;
    end
  end

  // Stage B2: cross product forward x up
  always_ff @(posedge clk) begin
    if (adv) begin
      c_b2[0] <= pb[0] - pb[1];
      c_b2[1] <= pb[2] - pb[3];
      c_b2[2] <= pb[4] - pb[5];
      eye_b2  <= eye_b1;
      f_b2    <= f_b1;
    end
  end

  // Side axis
  logic                    v2, zero2;
  logic [2:0][OW-1:0]      s2, f2;
  logic [SIDE2_W-1:0]      side2;
  logic [2:0][COORD_W-1:0] eye2;

  lav_unit3 #(
    .IN_W      (CW),
    .SIDE_W    (SIDE2_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_side (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vb2),
    .vec       (c_b2),
    .side_in   ({f_b2, eye_b2}),
    .out_valid (v2),
    .unit_vec  (s2),
    .zero      (zero2),
    .side_out  (side2)
  );

  assign {f2, eye2} = side2;

  // Stage C1: basis products and eye products
  logic [5:0]              vc;
  logic signed [BW-1:0]    ps [6];
  logic signed [EW-1:0]    pse [3], pfe [3];
  logic [2:0][OW-1:0]      s_c1, f_c1;
  logic [2:0][COORD_W-1:0] eye_c1;
  logic                    z_c1;

  always_ff @(posedge clk) begin
    if (adv) begin
      ps[0] <= BW'($signed(s2[1])) * BW'($signed(f2[2]));
      ps[1] <= BW'($signed(s2[2])) * BW'($signed(f2[1]));
      ps[2] <= BW'($signed(s2[2])) * BW'($signed(f2[0]));
      ps[3] <= BW'($signed(s2[0])) * BW'($signed(f2[2]));
      ps[4] <= BW'($signed(s2[0])) * BW'($signed(f2[1]));
      ps[5] <= BW'($signed(s2[1])) * BW'($signed(f2[0]));
      for (int i = 0; i < 3; i++) begin
        pse[i] <= EW'($signed(s2[i])) * EW'($signed(eye2[i]));
        pfe[i] <= EW'($signed(f2[i])) * EW'($signed(eye2[i]));
      end
      s_c1   <= s2;
      f_c1   <= f2;
      eye_c1 <= eye2;
      z_c1   <= zero2;
    end
  end

  // Stage C2: product differences and dot sums
  logic signed [BW:0]      ud [3];
  logic signed [DW-1:0]    dse, dfe;
  logic [2:0][OW-1:0]      s_c2, f_c2;
  logic [2:0][COORD_W-1:0] eye_c2;
  logic                    z_c2;

  always_ff @(posedge clk) begin
    if (adv) begin
      ud[0]  <= (BW+1)'(ps[0]) - (BW+1)'(ps[1]);
      ud[1]  <= (BW+1)'(ps[2]) - (BW+1)'(ps[3]);
      ud[2]  <= (BW+1)'(ps[4]) - (BW+1)'(ps[5]);
      dse    <= DW'(pse[0]) + DW'(pse[1]) + DW'(pse[2]);
      dfe    <= DW'(pfe[0]) + DW'(pfe[1]) + DW'(pfe[2]);
      s_c2   <= s_c1;
      f_c2   <= f_c1;
      eye_c2 <= eye_c1;
      z_c2   <= z_c1;
    end
  end

  // Stage C3: round true up and the side and forward translations
  logic [2:0][OW-1:0]      u_c3, s_c3, f_c3;
  logic signed [DW-1:0]    tx_c3, tz_c3;
  logic [2:0][COORD_W-1:0] eye_c3;
  logic                    z_c3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u_c3[i] <= clamp_one(rnd(DW'(ud[i])));
      end
      tx_c3  <= -rnd(dse);
      tz_c3  <= rnd(dfe);
      s_c3   <= s_c2;
      f_c3   <= f_c2;
      eye_c3 <= eye_c2;
      z_c3   <= z_c2;
    end
  end

  // Stage C4: true up times eye
  logic signed [EW-1:0]    pue [3];
  logic [2:0][OW-1:0]      u_c4, s_c4, f_c4;
  logic signed [DW-1:0]    tx_c4, tz_c4;
  logic                    z_c4;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pue[i] <= EW'($signed(u_c3[i])) * EW'($signed(eye_c3[i]));
      end
      u_c4  <= u_c3;
      s_c4  <= s_c3;
      f_c4  <= f_c3;
      tx_c4 <= tx_c3;
      tz_c4 <= tz_c3;
      z_c4  <= z_c3;
    end
  end

  // Stage C5: up dot eye
  logic signed [DW-1:0]    due;
  logic [2:0][OW-1:0]      u_c5, s_c5, f_c5;
  logic signed [DW-1:0]    tx_c5, tz_c5;
  logic                    z_c5;

  always_ff @(posedge clk) begin
    if (adv) begin
      due   <= DW'(pue[0]) + DW'(pue[1]) + DW'(pue[2]);
      u_c5  <= u_c4;
      s_c5  <= s_c4;
      f_c5  <= f_c4;
      tx_c5 <= tx_c4;
      tz_c5 <= tz_c4;
      z_c5  <= z_c4;
    end
  end

  // Stage C6: saturate translations, negate forward
  logic [2:0][OW-1:0]      u_c6, s_c6, b_c6;
  logic [2:0][COORD_W-1:0] t_c6;
  logic                    z_c6;

  always_ff @(posedge clk) begin
    if (adv) begin
      t_c6[0] <= sat32(tx_c5);
      t_c6[1] <= sat32(-rnd(due));
      t_c6[2] <= sat32(tz_c5);
      for (int i = 0; i < 3; i++) begin
        b_c6[i] <= -f_c5[i];
      end
      u_c6 <= u_c5;
      s_c6 <= s_c5;
      z_c6 <= z_c5;
    end
  end

  // Pack the result; a degenerate basis gives all zeros
  always_comb begin
    pd = '0;
    if (!z_c6) begin
      pd[FLD_W-1:0] = {t_c6, b_c6, u_c6, s_c6};
    end
  end

  // Valid bits through the top-level stages
  always_ff @(posedge clk) begin
    if (rst) begin
      va  <= 1'b0;
      vb1 <= 1'b0;
      vb2 <= 1'b0;
      vc  <= '0;
    end else if (adv) begin
      va  <= s_tvalid;
      vb1 <= v1;
      vb2 <= vb1;
      vc  <= {vc[4:0], v2};
    end
  end

  // Output register with skid: the pipeline holds only while the skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (!sv) begin
      if (!ov || m_tready) begin
        ov <= vc[5];
      end else if (vc[5]) begin
        sv <= 1'b1;
      end
    end else if (m_tready) begin
      ov <= 1'b1;
      sv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!sv) begin
      if (!ov || m_tready) begin
        od <= pd;
      end else begin
        sd <= pd;
      end
    end else if (m_tready) begin
      od <= sd;
    end
  end

  assign adv      = !sv;
  assign s_tready = adv;
  assign m_tvalid = ov;
  assign m_tdata  = od;

  // Skid only ever backs up a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst) sv |-> ov)
    else $error("skid holds a result while the output register is empty");

  // A result arriving at a stalled output goes to the skid
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (ov && !m_tready && vc[5] && !sv) |=> sv)
    else $error("result dropped at a stalled output");

  // Draining the skid refills the output and frees the pipeline
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (sv && m_tready) |=> (ov && !sv))
    else $error("skid drain lost a result");

  // Taken output with nothing behind it goes empty
  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (!sv && ov && m_tready && !vc[5]) |=> !ov)
    else $error("result repeated after it was taken");

endmodule
